// ----- sv/swhll_pkg.sv -----
// shared types, constants and saturating helpers for the shallow water hll flux unit
// no dependencies; imported by every module of the block except swhll_dly
package swhll_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_W        = 3;
  localparam int MUL_LAT       = 2;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_LAT       = DIV_STEPS + 2;

  localparam logic [30:0] THR_RESET  = 31'd66;
  localparam logic [30:0] GRAV_RESET = 31'd642908;

  // register index codes
  localparam logic REG_THR  = 1'b0;
  localparam logic REG_GRAV = 1'b1;

  // flux selection codes
  localparam logic [2:0] SEL_LOCAL = 3'd0;
  localparam logic [2:0] SEL_HLL   = 3'd1;
  localparam logic [2:0] SEL_NEIGH = 3'd2;
  localparam logic [2:0] SEL_ZERO  = 3'd3;
  localparam logic [2:0] SEL_ERR   = 3'd4;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic dz;
    logic nneg;
    logic nnz;
  } div_flags_t;

  typedef struct packed {
    logic signed [31:0] mass;
    logic signed [31:0] nmom;
    logic signed [31:0] tmom;
    logic               err;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = SAT_MAX;
    else if (x < -64'sd2147483648) r = SAT_MIN;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) r = s[32] ? SAT_MIN : SAT_MAX;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) r = s[32] ? SAT_MIN : SAT_MAX;
    else r = s[31:0];
    return r;
  endfunction

  // divide by two, rounding toward zero
  function automatic logic signed [31:0] half_tz(input logic signed [31:0] x);
    logic signed [32:0] t;
    t = {x[31], x} + {32'd0, x[31]};
    return t[32:1];
  endfunction

  // divide by four, rounding toward zero
  function automatic logic signed [31:0] quarter_tz(input logic signed [31:0] x);
    logic signed [32:0] t;
    t = {x[31], x} + (x[31] ? 33'sd3 : 33'sd0);
    return {t[32], t[32:2]};
  endfunction

endpackage

// ----- sv/swhll_dly.sv -----
// enable-gated delay line of fixed depth for pipeline alignment
// no dependencies
module swhll_dly #(
  parameter int W     = 32,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

// ----- sv/swhll_mul.sv -----
// saturating fixed point multiply, two register stages
// depends on swhll_pkg
module swhll_mul import swhll_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] y
);

  localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  logic signed [63:0] prod_r;
  logic signed [63:0] adj;
  logic signed [31:0] y_r;

  always_comb begin
    adj = prod_r + (prod_r[63] ? RND : 64'sd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
      y_r    <= sat32(adj >>> FRAC_BITS);
    end
  end

  assign y = y_r;

endmodule

// ----- sv/swhll_div.sv -----
// pipelined saturating signed divide, one quotient bit per stage
// depends on swhll_pkg
module swhll_div import swhll_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] y
);

  logic [63:0] mag_n;
  logic [31:0] mag_d;

  logic [31:0] rem_r [DIV_STEPS+1];
  logic [31:0] nlo_r [DIV_STEPS+1];
  logic [31:0] quo_r [DIV_STEPS+1];
  logic [31:0] dm_r  [DIV_STEPS+1];
  div_flags_t  fl_r  [DIV_STEPS+1];
  logic signed [31:0] y_r;
  logic [31:0] qf;
  div_flags_t  ff;

  always_comb begin
    mag_n = num[63] ? (~num + 64'd1) : num;
    mag_d = den[31] ? (~den + 32'd1) : den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]     <= mag_n[63:32];
      nlo_r[0]     <= mag_n[31:0];
      quo_r[0]     <= '0;
      dm_r[0]      <= mag_d;
      fl_r[0].neg  <= num[63] ^ den[31];
      fl_r[0].ovf  <= (mag_n[63:32] >= mag_d);
      fl_r[0].dz   <= (mag_d == 32'd0);
      fl_r[0].nneg <= num[63];
      fl_r[0].nnz  <= (num != 64'sd0);
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [32:0] t;
    logic        ge;
    always_comb begin
      t  = {rem_r[i], nlo_r[i][31]};
      ge = (t >= {1'b0, dm_r[i]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? 32'(t - {1'b0, dm_r[i]}) : t[31:0];
        nlo_r[i+1] <= {nlo_r[i][30:0], 1'b0};
        quo_r[i+1] <= {quo_r[i][30:0], ge};
        dm_r[i+1]  <= dm_r[i];
        fl_r[i+1]  <= fl_r[i];
      end
    end
  end

  assign qf = quo_r[DIV_STEPS];
  assign ff = fl_r[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ff.dz) begin
        y_r <= ff.nnz ? (ff.nneg ? SAT_MIN : SAT_MAX) : 32'sd0;
      end else if (ff.neg) begin
        y_r <= (ff.ovf || qf > 32'h8000_0000) ? SAT_MIN : $signed(~qf + 32'd1);
      end else begin
        y_r <= (ff.ovf || qf[31]) ? SAT_MAX : $signed(qf);
      end
    end
  end

  assign y = y_r;

endmodule

// ----- sv/swhll_sqrt.sv -----
// pipelined integer square root of x scaled by the fraction bits, one root bit per stage
// depends on swhll_pkg
module swhll_sqrt import swhll_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x,
  output logic signed [31:0] y
);

  localparam int VW   = 31 + FRAC_BITS;
  localparam int ITER = (VW + 1) / 2;
  localparam int PW   = 2 * ITER;
  localparam int RW   = ITER + 2;

  logic [RW-1:0]   rem_r  [ITER+1];
  logic [ITER-1:0] root_r [ITER+1];
  logic [PW-1:0]   vs_r   [ITER+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      vs_r[0]   <= (x > 32'sd0) ? PW'({x[30:0], {FRAC_BITS{1'b0}}}) : '0;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_step
    logic [RW-1:0] t;
    logic [RW-1:0] trial;
    logic          ge;
    always_comb begin
      t     = {rem_r[i][RW-3:0], vs_r[i][PW-1:PW-2]};
      trial = {root_r[i], 2'b01};
      ge    = (t >= trial);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= ge ? (t - trial) : t;
        root_r[i+1] <= {root_r[i][ITER-2:0], ge};
        vs_r[i+1]   <= {vs_r[i][PW-3:0], 2'b00};
      end
    end
  end

  assign y = $signed(32'(root_r[ITER]));

endmodule

// ----- sv/shallow_water_hll_flux.sv -----
// top level of the shallow water hll flux unit: config registers, wave speeds, output buffer
// depends on swhll_pkg, swhll_dly, swhll_mul, swhll_div, swhll_sqrt
//
// one face node per input transaction (depth, normal and tangential discharge on both
// sides); one result transaction per node with the three hll fluxes and a speed error flag
// both channels are valid/ready; the apb port sets the dry threshold and gravity
// throughput: one transaction per cycle, sustained while the receiver keeps out_ready high
// the path from input acceptance to out_valid is set by two
// chained 34-stage dividers (one quotient bit per stage) plus the wave speed stages
// a two-entry output buffer (output register plus skid register) decouples the sides:
// input is still taken while a result waits, until the skid register fills; then the
// whole pipeline holds and in_ready is low until the receiver takes a result
// reset clears all valid bits and loads the register defaults (threshold 66,
// gravity 642908); in-flight transactions are dropped
module shallow_water_hll_flux import swhll_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_depth_local,
  input  logic signed [31:0] in_depth_neighbour,
  input  logic signed [31:0] in_normal_discharge_local,
  input  logic signed [31:0] in_normal_discharge_neighbour,
  input  logic signed [31:0] in_tangent_discharge_local,
  input  logic signed [31:0] in_tangent_discharge_neighbour,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_mass_flux,
  output logic signed [31:0] out_normal_momentum_flux,
  output logic signed [31:0] out_tangent_momentum_flux,
  output logic               out_speed_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SQ_ITER = (32 + FRAC_BITS) / 2;
  localparam int SQ_LAT  = SQ_ITER + 1;
  localparam int T_U     = DIV_LAT;
  localparam int T_C     = MUL_LAT + SQ_LAT;
  localparam int T_P     = 2 * MUL_LAT;
  localparam int T_ED    = 1 + DIV_LAT;
  localparam int T_E     = T_ED + 1;
  localparam int T_S     = T_U + 5;
  localparam int T_N     = T_S + 2 * MUL_LAT + 1;
  localparam int T_F     = T_N + DIV_LAT;

  // configuration
  logic [30:0] thr_r;
  logic [30:0] grav_r;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      grav_r <= GRAV_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_THR:  thr_r  <= pwdata[30:0];
        REG_GRAV: grav_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THR:  prdata = {1'b0, thr_r};
      REG_GRAV: prdata = {1'b0, grav_r};
      default:  prdata = '0;
    endcase
  end

  // pipeline control
  logic             en;
  logic [T_F-1:0]   vld_r;
  logic             push;
  logic             pop;
  logic             out_v_r;
  logic             skid_v_r;
  res_t             out_res_r;
  res_t             skid_res_r;
  res_t             res_nxt;

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[T_F-2:0], in_valid};
  end

  assign push = vld_r[T_F-1] && en;
  assign pop  = out_v_r && out_ready;

  // per-side front end
  logic signed [31:0] h_in [2];
  logic signed [31:0] q_in [2];
  logic signed [31:0] v_in [2];
  logic               wet_in [2];
  logic signed [31:0] dx_in [3];
  logic signed [31:0] c_d [2];
  logic signed [31:0] u_d [2];
  logic               w_u [2];
  logic signed [31:0] e_s [2][3];
  logic signed [31:0] e_f [2][3];

  assign h_in[0] = in_depth_local;
  assign h_in[1] = in_depth_neighbour;
  assign q_in[0] = in_normal_discharge_local;
  assign q_in[1] = in_normal_discharge_neighbour;
  assign v_in[0] = in_tangent_discharge_local;
  assign v_in[1] = in_tangent_discharge_neighbour;
  assign dx_in[0] = ssub(h_in[1], h_in[0]);
  assign dx_in[1] = ssub(q_in[1], q_in[0]);
  assign dx_in[2] = ssub(v_in[1], v_in[0]);

  for (genvar s = 0; s < 2; s++) begin : g_side
    logic signed [31:0] gh, h_d1, h_d2, ph, p_d, c_raw;
    logic signed [31:0] e1_div, e2_div, q_d;
    logic signed [63:0] qq_r, qv_r, q_sh;
    logic               w_e;
    logic signed [31:0] e_r [3];

    assign wet_in[s] = h_in[s] > $signed({1'b0, thr_r});
    assign q_sh      = {{32{q_in[s][31]}}, q_in[s]} <<< FRAC_BITS;

    swhll_mul #(.FRAC_BITS(FRAC_BITS)) u_gh (
      .clk, .en, .a($signed({1'b0, grav_r})), .b(h_in[s]), .y(gh)
    );
    swhll_dly #(.W(32), .DEPTH(1)) u_hd1 (.clk, .en, .d(h_in[s]), .q(h_d1));
    swhll_dly #(.W(32), .DEPTH(1)) u_hd2 (.clk, .en, .d(h_d1), .q(h_d2));
    swhll_mul #(.FRAC_BITS(FRAC_BITS)) u_p (.clk, .en, .a(gh), .b(h_d2), .y(ph));
    swhll_dly #(.W(32), .DEPTH(T_ED - T_P)) u_pd (.clk, .en, .d(half_tz(ph)), .q(p_d));
    swhll_sqrt #(.FRAC_BITS(FRAC_BITS)) u_c (.clk, .en, .x(gh), .y(c_raw));
    swhll_dly #(.W(32), .DEPTH(T_U - T_C)) u_cd (.clk, .en, .d(c_raw), .q(c_d[s]));
    swhll_div u_u (.clk, .en, .num(q_sh), .den(h_in[s]), .y(u_d[s]));

    always_ff @(posedge clk) begin
      if (en) begin
        qq_r <= q_in[s] * q_in[s];
        qv_r <= q_in[s] * v_in[s];
      end
    end

    swhll_div u_e1 (.clk, .en, .num(qq_r), .den(h_d1), .y(e1_div));
    swhll_div u_e2 (.clk, .en, .num(qv_r), .den(h_d1), .y(e2_div));
    swhll_dly #(.W(32), .DEPTH(T_ED)) u_qd (.clk, .en, .d(q_in[s]), .q(q_d));
    swhll_dly #(.W(1), .DEPTH(T_ED)) u_we (.clk, .en, .d(wet_in[s]), .q(w_e));
    swhll_dly #(.W(1), .DEPTH(T_U)) u_wu (.clk, .en, .d(wet_in[s]), .q(w_u[s]));

    always_ff @(posedge clk) begin
      if (en) begin
        e_r[0] <= w_e ? q_d : 32'sd0;
        e_r[1] <= w_e ? sadd(e1_div, p_d) : 32'sd0;
        e_r[2] <= w_e ? e2_div : 32'sd0;
      end
    end

    for (genvar k = 0; k < 3; k++) begin : g_e
      swhll_dly #(.W(32), .DEPTH(T_S - T_E)) u_es (.clk, .en, .d(e_r[k]), .q(e_s[s][k]));
      swhll_dly #(.W(32), .DEPTH(T_F - T_S)) u_ef (.clk, .en, .d(e_s[s][k]), .q(e_f[s][k]));
    end
  end

  // wave speed stages
  logic signed [31:0] a1_r, b1_r, d1_r, lmc1_r, npc1_r, c2l1_r, c2n1_r;
  logic signed [31:0] ul1_r, un1_r, cl1_r, cn1_r;
  logic               wl1_r, wn1_r;
  logic signed [31:0] us02_r, cs2_r, lmc2_r, npc2_r, wdn2_r, dwl2_r, cn2_r;
  logic               wl2_r, wn2_r;
  logic signed [31:0] us3_r, cs3_r, lmc3_r, npc3_r, wdn3_r, dwl3_r;
  logic               wl3_r, wn3_r;
  logic signed [31:0] blo4_r, bhi4_r, lmc4_r, npc4_r, wdn4_r, dwl4_r;
  logic               wl4_r, wn4_r;
  logic signed [31:0] sl_nxt, sn_nxt, sl_r, sn_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= sadd(u_d[0], u_d[1]);
      b1_r   <= sadd(c_d[0], c_d[1]);
      d1_r   <= ssub(u_d[0], u_d[1]);
      lmc1_r <= ssub(u_d[0], c_d[0]);
      npc1_r <= sadd(u_d[1], c_d[1]);
      c2l1_r <= sadd(c_d[0], c_d[0]);
      c2n1_r <= sadd(c_d[1], c_d[1]);
      ul1_r  <= u_d[0];
      un1_r  <= u_d[1];
      cl1_r  <= c_d[0];
      cn1_r  <= c_d[1];
      wl1_r  <= w_u[0];
      wn1_r  <= w_u[1];

      us02_r <= sadd(half_tz(a1_r), cl1_r);
      cs2_r  <= sadd(half_tz(b1_r), quarter_tz(d1_r));
      lmc2_r <= lmc1_r;
      npc2_r <= npc1_r;
      wdn2_r <= sadd(ul1_r, c2l1_r);
      dwl2_r <= ssub(un1_r, c2n1_r);
      cn2_r  <= cn1_r;
      wl2_r  <= wl1_r;
      wn2_r  <= wn1_r;

      us3_r  <= ssub(us02_r, cn2_r);
      cs3_r  <= cs2_r;
      lmc3_r <= lmc2_r;
      npc3_r <= npc2_r;
      wdn3_r <= wdn2_r;
      dwl3_r <= dwl2_r;
      wl3_r  <= wl2_r;
      wn3_r  <= wn2_r;

      blo4_r <= ssub(us3_r, cs3_r);
      bhi4_r <= sadd(us3_r, cs3_r);
      lmc4_r <= lmc3_r;
      npc4_r <= npc3_r;
      wdn4_r <= wdn3_r;
      dwl4_r <= dwl3_r;
      wl4_r  <= wl3_r;
      wn4_r  <= wn3_r;

      sl_r   <= sl_nxt;
      sn_r   <= sn_nxt;
    end
  end

  always_comb begin
    if (wl4_r && wn4_r) begin
      sl_nxt = (lmc4_r < blo4_r) ? lmc4_r : blo4_r;
      sn_nxt = (npc4_r > bhi4_r) ? npc4_r : bhi4_r;
    end else if (wl4_r) begin
      sl_nxt = lmc4_r;
      sn_nxt = wdn4_r;
    end else if (wn4_r) begin
      sl_nxt = dwl4_r;
      sn_nxt = npc4_r;
    end else begin
      sl_nxt = 32'sd0;
      sn_nxt = 32'sd0;
    end
  end

  // hll combination
  logic [2:0]         sel_nxt, sel_f;
  logic signed [31:0] ss, den_d;
  logic signed [31:0] f_div [3];
  logic signed [31:0] f_sel [3];

  always_comb begin
    if (!sl_r[31] && sn_r > 32'sd0) sel_nxt = SEL_LOCAL;
    else if (sl_r[31] && sn_r > 32'sd0) sel_nxt = SEL_HLL;
    else if (sl_r[31]) sel_nxt = SEL_NEIGH;
    else if (sl_r == 32'sd0 && sn_r == 32'sd0) sel_nxt = SEL_ZERO;
    else sel_nxt = SEL_ERR;
  end

  swhll_dly #(.W(3), .DEPTH(T_F - T_S)) u_seld (.clk, .en, .d(sel_nxt), .q(sel_f));
  swhll_mul #(.FRAC_BITS(FRAC_BITS)) u_ss (.clk, .en, .a(sl_r), .b(sn_r), .y(ss));
  swhll_dly #(.W(32), .DEPTH(T_N - T_S)) u_dend (
    .clk, .en, .d(ssub(sn_r, sl_r)), .q(den_d)
  );

  for (genvar k = 0; k < 3; k++) begin : g_flux
    logic signed [31:0] m1, m2, m3, d12_r, d12_d, dx_d, num_r;
    logic signed [63:0] num_sh;

    swhll_mul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clk, .en, .a(sn_r), .b(e_s[0][k]), .y(m1));
    swhll_mul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.clk, .en, .a(sl_r), .b(e_s[1][k]), .y(m2));
    swhll_dly #(.W(32), .DEPTH(MUL_LAT - 1)) u_d12 (.clk, .en, .d(d12_r), .q(d12_d));
    swhll_dly #(.W(32), .DEPTH(T_S + MUL_LAT)) u_dx (.clk, .en, .d(dx_in[k]), .q(dx_d));
    swhll_mul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.clk, .en, .a(ss), .b(dx_d), .y(m3));

    always_ff @(posedge clk) begin
      if (en) begin
        d12_r <= ssub(m1, m2);
        num_r <= sadd(d12_d, m3);
      end
    end

    assign num_sh = {{32{num_r[31]}}, num_r} <<< FRAC_BITS;

    swhll_div u_f (.clk, .en, .num(num_sh), .den(den_d), .y(f_div[k]));

    always_comb begin
      case (sel_f)
        SEL_LOCAL: f_sel[k] = e_f[0][k];
        SEL_NEIGH: f_sel[k] = e_f[1][k];
        SEL_HLL:   f_sel[k] = f_div[k];
        default:   f_sel[k] = 32'sd0;
      endcase
    end
  end

  always_comb begin
    res_nxt.mass = f_sel[0];
    res_nxt.nmom = f_sel[1];
    res_nxt.tmom = f_sel[2];
    res_nxt.err  = (sel_f == SEL_ERR);
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) skid_v_r <= 1'b0;
    end else if (push) begin
      if (!out_v_r || pop) out_v_r <= 1'b1;
      else skid_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) out_res_r <= skid_res_r;
    end else if (push) begin
      if (!out_v_r || pop) out_res_r <= res_nxt;
      else skid_res_r <= res_nxt;
    end
  end

  assign out_valid                 = out_v_r;
  assign out_mass_flux             = out_res_r.mass;
  assign out_normal_momentum_flux  = out_res_r.nmom;
  assign out_tangent_momentum_flux = out_res_r.tmom;
  assign out_speed_error           = out_res_r.err;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a transaction while output register is empty");

  a_err_zero_flux: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.err) |->
      (out_res_r.mass == 32'sd0 && out_res_r.nmom == 32'sd0 && out_res_r.tmom == 32'sd0))
    else $error("speed error result carries nonzero flux");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_v_r && !skid_v_r))
    else $error("output buffer not empty after reset");

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the shallow water hll flux unit
// depends on swhll_pkg and shallow_water_hll_flux; drives directed and random face nodes and
// checks every result transaction against a fixed-point flux predictor
`timescale 1ns / 1ps

module tb_top;
  import swhll_pkg::*;

  typedef struct {
    logic signed [31:0] h_l, h_n, q_l, q_n, v_l, v_n;
  } face_node_t;

  typedef struct {
    logic signed [31:0] mass, nmom, tmom;
    logic               err;
  } flux_t;

  typedef struct {
    face_node_t node;
    bit         typed;
    flux_t      flux;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic signed [31:0] in_depth_local = 0, in_depth_neighbour = 0;
  logic signed [31:0] in_normal_discharge_local = 0, in_normal_discharge_neighbour = 0;
  logic signed [31:0] in_tangent_discharge_local = 0, in_tangent_discharge_neighbour = 0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] out_mass_flux, out_normal_momentum_flux, out_tangent_momentum_flux;
  logic out_speed_error;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  shallow_water_hll_flux dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  longint dry_thr = THR_RESET;
  longint grav = GRAV_RESET;
  flux_t pending_flux[$];
  int n_fail = 0, n_checked = 0, n_sent = 0, n_err_seen = 0;
  int send_idle = 0, recv_idle = 0, hold_cycles = 0;

  // fixed-point helpers, 64-bit exact before saturation
  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat((a * b) / 65536);
  endfunction

  function automatic longint fx_muldiv(longint a, longint b, longint c);
    longint p;
    p = a * b;
    if (c == 0) return (p > 0) ? 64'sd2147483647 : (p < 0) ? -64'sd2147483648 : 0;
    return sat(p / c);
  endfunction

  function automatic longint fx_sqrt(longint x);
    longint unsigned v, r, b;
    if (x <= 0) return 0;
    v = longint'(x) << 16;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return sat(longint'(r));
  endfunction

  function automatic void phys_flux(longint h, longint q, longint v, output longint e[3]);
    longint p;
    if (h > dry_thr) begin
      p = fx_mul(fx_mul(grav, h), h) / 2;
      e[0] = q;
      e[1] = sat(fx_muldiv(q, q, h) + p);
      e[2] = fx_muldiv(q, v, h);
    end else begin
      e = '{0, 0, 0};
    end
  endfunction

  function automatic flux_t hll_flux(face_node_t n);
    longint xl[3], xn[3], el[3], en[3], f[3];
    longint s_l, s_n, u_l, u_n, c_l, c_n, us, cs, a, b, den, ss, num;
    bit wet_l, wet_n, err;
    flux_t r;
    xl = '{n.h_l, n.q_l, n.v_l};
    xn = '{n.h_n, n.q_n, n.v_n};
    f = '{0, 0, 0};
    err = 0;
    phys_flux(xl[0], xl[1], xl[2], el);
    phys_flux(xn[0], xn[1], xn[2], en);
    wet_l = xl[0] > dry_thr;
    wet_n = xn[0] > dry_thr;
    c_l = fx_sqrt(fx_mul(grav, xl[0]));
    c_n = fx_sqrt(fx_mul(grav, xn[0]));
    if (wet_l && wet_n) begin
      u_l = fx_muldiv(xl[1], 65536, xl[0]);
      u_n = fx_muldiv(xn[1], 65536, xn[0]);
      us = sat(sat(sat(u_l + u_n) / 2 + c_l) - c_n);
      cs = sat(sat(c_l + c_n) / 2 + sat(u_l - u_n) / 4);
      a = sat(u_l - c_l);
      b = sat(us - cs);
      s_l = (a < b) ? a : b;
      a = sat(u_n + c_n);
      b = sat(us + cs);
      s_n = (a > b) ? a : b;
    end else if (wet_l) begin
      u_l = fx_muldiv(xl[1], 65536, xl[0]);
      s_l = sat(u_l - c_l);
      s_n = sat(u_l + sat(c_l + c_l));
    end else if (wet_n) begin
      u_n = fx_muldiv(xn[1], 65536, xn[0]);
      s_l = sat(u_n - sat(c_n + c_n));
      s_n = sat(u_n + c_n);
    end else begin
      s_l = 0;
      s_n = 0;
    end
    if (s_l >= 0 && s_n > 0) begin
      f = el;
    end else if (s_l < 0 && s_n > 0) begin
      den = sat(s_n - s_l);
      ss = fx_mul(s_l, s_n);
      for (int k = 0; k < 3; k++) begin
        num = sat(fx_mul(s_n, el[k]) - fx_mul(s_l, en[k]));
        num = sat(num + fx_mul(ss, sat(xn[k] - xl[k])));
        f[k] = fx_muldiv(num, 65536, den);
      end
    end else if (s_l < 0 && s_n <= 0) begin
      f = en;
    end else if (!(s_l == 0 && s_n == 0)) begin
      err = 1;
    end
    r.mass = f[0][31:0];
    r.nmom = f[1][31:0];
    r.tmom = f[2][31:0];
    r.err = err;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
    n_fail++;
  endtask

  // result monitor
  always @(posedge clk) begin
    flux_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_flux.size() == 0) begin
        report_mismatch("unexpected transaction", out_mass_flux, 0);
      end else begin
        w = pending_flux.pop_front();
        n_checked++;
        if (out_speed_error) n_err_seen++;
        if (out_mass_flux !== w.mass) report_mismatch("mass_flux", out_mass_flux, w.mass);
        if (out_normal_momentum_flux !== w.nmom)
          report_mismatch("normal_momentum_flux", out_normal_momentum_flux, w.nmom);
        if (out_tangent_momentum_flux !== w.tmom)
          report_mismatch("tangent_momentum_flux", out_tangent_momentum_flux, w.tmom);
        if (out_speed_error !== w.err)
          report_mismatch("speed_error", 32'(out_speed_error), 32'(w.err));
      end
    end
  end

  // receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic cfg_write(logic reg_idx, logic [31:0] value);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = ADDR_W'(reg_idx) << 2;
    pwdata = value;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    if (reg_idx == REG_THR) dry_thr = value & 32'h7fff_ffff;
    else grav = value & 32'h7fff_ffff;
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_node(face_node_t n, bit typed, flux_t want);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_depth_local = n.h_l;
    in_depth_neighbour = n.h_n;
    in_normal_discharge_local = n.q_l;
    in_normal_discharge_neighbour = n.q_n;
    in_tangent_discharge_local = n.v_l;
    in_tangent_discharge_neighbour = n.v_n;
    do @(posedge clk); while (!in_ready);
    pending_flux.push_back(typed ? want : hll_flux(n));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending_flux.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_depth();
    longint t;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(32'h0064_0000, 32'h0000_4000);
      5: begin
        t = dry_thr + $urandom_range(4) - 2;
        return (t > 64'sd2147483647) ? 32'sh7fff_ffff : 32'(t);
      end
      6: return -$signed(32'($urandom_range(32'h0100_0000)));
      7: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_discharge();
    case ($urandom_range(7))
      0, 1, 2, 3: return $signed(32'($urandom_range(32'h0080_0000))) - 32'sh0040_0000;
      4: return $signed(32'($urandom_range(32'h1000_0000))) - 32'sh0800_0000;
      5: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic face_node_t rand_node();
    face_node_t n;
    n.h_l = rand_depth();
    n.h_n = rand_depth();
    n.q_l = rand_discharge();
    n.q_n = rand_discharge();
    n.v_l = rand_discharge();
    n.v_n = rand_discharge();
    return n;
  endfunction

  task automatic random_phase(int count);
    flux_t none;
    none = '{0, 0, 0, 0};
    for (int i = 0; i < count; i++) send_node(rand_node(), 0, none);
  endtask

  initial begin
    stim_row_t rows[$];
    flux_t zero_flux;
    zero_flux = '{0, 0, 0, 0};

    // dry on both sides, so every flux is zero
    rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, zero_flux});
    rows.push_back('{'{-1, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                      32'sh7fff_ffff, 32'sh8000_0000}, 1, zero_flux});
    rows.push_back('{'{66, 66, 32'h0001_0000, -32'sh0001_0000, 5, -5}, 1, zero_flux});
    // still water, wet/wet
    rows.push_back('{'{32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0}, 0, zero_flux});
    rows.push_back('{'{67, 67, 0, 0, 0, 0}, 0, zero_flux});
    // dam break both ways
    rows.push_back('{'{32'h000a_0000, 32'h0001_0000, 0, 0, 0, 0}, 0, zero_flux});
    rows.push_back('{'{32'h0001_0000, 32'h000a_0000, 0, 0, 0, 0}, 0, zero_flux});
    // wet/dry and dry/wet
    rows.push_back('{'{32'h0002_0000, 0, 32'h0001_0000, 0, 32'h0000_8000, 0}, 0, zero_flux});
    rows.push_back('{'{-5, 32'h0002_0000, 0, -32'sh0001_0000, 0, 32'h0003_0000}, 0, zero_flux});
    // supercritical flow in both directions
    rows.push_back('{'{32'h0001_0000, 32'h0001_0000, 32'h0020_0000, 32'h0020_0000,
                      32'h0001_0000, 32'h0002_0000}, 0, zero_flux});
    rows.push_back('{'{32'h0001_0000, 32'h0001_0000, -32'sh0020_0000, -32'sh0020_0000,
                      -32'sh0001_0000, 32'h0002_0000}, 0, zero_flux});
    // extremes that saturate
    rows.push_back('{'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                      32'sh8000_0000, 32'sh7fff_ffff}, 0, zero_flux});
    rows.push_back('{'{67, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                      32'sh7fff_ffff, 32'sh8000_0000}, 0, zero_flux});
    rows.push_back('{'{32'sh7fff_ffff, 67, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      32'sh8000_0000, 32'sh8000_0000}, 0, zero_flux});
    rows.push_back('{'{32'sh5555_5555, 32'sh2aaa_aaaa, 32'shaaaa_aaaa, 32'sh5555_5555,
                      32'sh5555_5555, 32'shaaaa_aaaa}, 0, zero_flux});
    rows.push_back('{'{1, 32'h0000_0100, 32'sh0000_ffff, -1, 1, -1}, 0, zero_flux});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    send_idle = 10;
    recv_idle = 54;
    foreach (rows[i]) send_node(rows[i].node, rows[i].typed, rows[i].flux);
    random_phase(250);
    drain();

    // tiny threshold, strongest gravity
    cfg_write(REG_THR, 0);
    cfg_write(REG_GRAV, 32'h7fff_ffff);
    random_phase(250);
    drain();

    send_idle = 54;
    recv_idle = 10;
    cfg_write(REG_THR, 32'h7fff_ffff);
    cfg_write(REG_GRAV, 0);
    foreach (rows[i]) if (!rows[i].typed) send_node(rows[i].node, 0, zero_flux);
    random_phase(200);
    drain();

    cfg_write(REG_THR, 32'h0000_0400);
    cfg_write(REG_GRAV, 32'h0001_0000);
    random_phase(250);
    drain();

    send_idle = 0;
    recv_idle = 0;
    cfg_write(REG_THR, $urandom_range(32'h0000_1000));
    cfg_write(REG_GRAV, $urandom_range(32'h0010_0000, 32'h0008_0000));
    hold_cycles = 400;
    random_phase(250);
    drain();

    cfg_write(REG_THR, 32'hffff_ffff);
    cfg_write(REG_THR, THR_RESET);
    cfg_write(REG_GRAV, GRAV_RESET);
    random_phase(220);
    drain();

    $display("sent %0d face nodes over six register settings, checked %0d results",
             n_sent, n_checked);
    $display("%0d results carried the speed error flag, %0d mismatches", n_err_seen, n_fail);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", pending_flux.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/swhll_pkg.sv
sv/swhll_dly.sv
sv/swhll_mul.sv
sv/swhll_div.sv
sv/swhll_sqrt.sv
sv/shallow_water_hll_flux.sv
verif/tb_top.sv
